@@ src/text_console_writer_top_assert.svh @@
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shared property wrappers for the console port checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset
`define TCW_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define TCW_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// Text console writer package
// Screen geometry, character codes, request kinds and controller commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  // Screen geometry
  localparam int SCREEN_ROWS = 25;
  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_CELLS = SCREEN_ROWS * SCREEN_COLS;

  // Widths derived from the geometry
  localparam int ROW_W  = $clog2(SCREEN_ROWS);
  localparam int CIDX_W = $clog2(SCREEN_COLS);
  localparam int COL_W  = $clog2(SCREEN_COLS + 1);
  localparam int ADDR_W = $clog2(SCREEN_CELLS);

  // Character and attribute codes
  localparam logic [7:0] RESET_COLOR  = 8'd14;
  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0a;
  localparam logic [7:0] PRINT_LOW    = 8'h20;
  localparam logic [7:0] PRINT_HIGH   = 8'h7e;
  localparam logic [7:0] SUBST_CHAR   = 8'hfe;

  // Request kinds
  localparam logic [1:0] KIND_RAW  = 2'd0;
  localparam logic [1:0] KIND_TEXT = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // Register word index
  localparam logic REG_TEXT_COLOR = 1'b0;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the incoming request
    logic execute;   // update the screen or issue the cell read
    logic load_out;  // move the result into the output register
  } tcw_cmd_t;

endpackage

`default_nettype wire

@@ src/tcw_ctrl.sv @@
// ----------------------------------------------------------------------------
// Text console writer controller
// Sequences one request at a time through capture, execute and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  output tcw_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESULT
  } state_t;

  state_t state;
  logic   out_valid;

  // Decode commands from the current state
  always_comb begin
    s_tready     = (state == ST_IDLE);
    cmd.capture  = s_tvalid && (state == ST_IDLE);
    cmd.execute  = (state == ST_EXEC);
    cmd.load_out = (state == ST_RESULT) && (!out_valid || m_tready);
  end

  assign m_tvalid = out_valid;

  // Advance state, hold the output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd.capture) state <= ST_EXEC;
        end
        ST_EXEC: begin
          state <= ST_RESULT;
        end
        ST_RESULT: begin
          if (cmd.load_out) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/tcw_datapath.sv @@
// ----------------------------------------------------------------------------
// Text console writer datapath
// Screen memory on a circular row ring, per-row fill counts and blank colors,
// cursor column, color register and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_datapath
  import tcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  tcw_cmd_t    cmd,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_char_byte,
  input  logic [4:0]  in_read_row,
  input  logic [6:0]  in_read_col,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  output logic [7:0]  text_color,
  output logic [23:0] out_data
);

  // Captured request
  logic [1:0] kind;
  logic [7:0] char_byte;
  logic [4:0] read_row;
  logic [6:0] read_col;

  // Screen state: physical row of the top line, cursor, per-row bookkeeping.
  // Cells of a row at or beyond its fill count read as blanks in its color.
  logic [ROW_W-1:0] top;
  logic [COL_W-1:0] column;
  logic [COL_W-1:0] fill [SCREEN_ROWS];
  logic [7:0]       blank_color [SCREEN_ROWS];

  // Screen memory, character in the low byte
  logic [15:0] mem [SCREEN_CELLS];
  logic [15:0] rd_data;

  // Execute results
  logic       res_read;
  logic       res_inrange;
  logic       res_hit;
  logic [7:0] res_bcolor;
  logic       res_scrolled;

  // Output register
  logic [7:0] out_char;
  logic [7:0] out_color;
  logic [6:0] out_cursor;
  logic       out_scrolled;

  // Combinational decode
  logic              is_read;
  logic              is_write;
  logic [7:0]        wr_char;
  logic              newline;
  logic              do_scroll;
  logic [ROW_W-1:0]  bottom;
  logic [ROW_W-1:0]  top_inc;
  logic [ROW_W-1:0]  wr_phys;
  logic [CIDX_W-1:0] wr_col;
  logic [ROW_W:0]    rsum;
  logic [ROW_W-1:0]  rphys;
  logic              inrange;
  logic [ROW_W-1:0]  addr_row;
  logic [CIDX_W-1:0] addr_col;
  logic [ADDR_W-1:0] addr;
  logic              mem_we;

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind      <= in_kind;
      char_byte <= in_char_byte;
      read_row  <= in_read_row;
      read_col  <= in_read_col;
    end
  end

  // Decode the request and form the memory address
  always_comb begin
    is_read  = (kind == KIND_READ);
    is_write = (kind == KIND_RAW) || (kind == KIND_TEXT);
    wr_char  = char_byte;
    if ((kind == KIND_TEXT) && (char_byte != NEWLINE_CHAR) &&
        ((char_byte < PRINT_LOW) || (char_byte > PRINT_HIGH))) begin
      wr_char = SUBST_CHAR;
    end
    newline   = (wr_char == NEWLINE_CHAR);
    do_scroll = is_write && (newline || (32'(column) >= SCREEN_COLS));

    bottom  = (top == '0) ? ROW_W'(SCREEN_ROWS - 1) : top - 1'b1;
    top_inc = (top == ROW_W'(SCREEN_ROWS - 1)) ? '0 : top + 1'b1;
    wr_phys = do_scroll ? top : bottom;
    wr_col  = do_scroll ? '0 : CIDX_W'(column);

    // Map the logical read row onto the ring
    rsum    = {1'b0, ROW_W'(read_row)} + {1'b0, top};
    rphys   = (rsum >= (ROW_W + 1)'(SCREEN_ROWS)) ?
              ROW_W'(rsum - (ROW_W + 1)'(SCREEN_ROWS)) : ROW_W'(rsum);
    inrange = (32'(read_row) < SCREEN_ROWS) && (32'(read_col) < SCREEN_COLS);

    addr_row = is_read ? rphys : wr_phys;
    addr_col = is_read ? CIDX_W'(read_col) : wr_col;
    addr     = ADDR_W'(addr_row) * ADDR_W'(SCREEN_COLS) + ADDR_W'(addr_col);
    mem_we   = cmd.execute && is_write && !newline;
  end

  // Screen memory port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= {text_color, wr_char};
    end
    rd_data <= mem[addr];
  end

  // Update cursor, ring and row bookkeeping; take register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= RESET_COLOR;
      top        <= '0;
      column     <= '0;
      for (int r = 0; r < SCREEN_ROWS; r++) begin
        fill[r]        <= '0;
        blank_color[r] <= RESET_COLOR;
      end
    end else begin
      if (cfg_we) text_color <= cfg_wdata;
      if (cmd.execute && is_write) begin
        if (newline) begin
          column        <= '0;
          fill[wr_phys] <= '0;
        end else begin
          column        <= COL_W'(wr_col) + 1'b1;
          fill[wr_phys] <= COL_W'(wr_col) + 1'b1;
        end
        if (do_scroll) begin
          top                  <= top_inc;
          blank_color[wr_phys] <= text_color;
        end
      end
    end
  end

  // Hold what the result needs from the execute step
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      res_read     <= is_read;
      res_inrange  <= inrange;
      res_hit      <= COL_W'(read_col) < fill[rphys];
      res_bcolor   <= blank_color[rphys];
      res_scrolled <= do_scroll;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (res_read && res_inrange) begin
        out_char  <= res_hit ? rd_data[7:0] : BLANK_CHAR;
        out_color <= res_hit ? rd_data[15:8] : res_bcolor;
      end else begin
        out_char  <= '0;
        out_color <= '0;
      end
      out_cursor   <= 7'(column);
      out_scrolled <= res_scrolled;
    end
  end

  assign out_data = {out_scrolled, out_cursor, out_color, out_char};

endmodule

`default_nettype wire

@@ src/text_console_writer_top.sv @@
// ----------------------------------------------------------------------------
// Text console writer top level
// Character screen with bottom-line cursor, scroll on newline or full line, and cell readback.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ stream; s_tuser holds the kind (raw write,
//   filtered text write, cell read) and s_tdata the byte and read position.
//   Every request gives exactly one result on the m_ stream with the read
//   cell, the cursor column after the request and a scroll flag.
//   The text color register sits at address 0 of the APB port; write it only
//   while no request is in flight.
//   Steps: a request passes capture, execute and result in the controller,
//   with the registered read of the single-port screen memory, and m_tvalid
//   rises when the result is loaded into the output register. One request
//   is in flight at a time: a new one is taken only after the last result is
//   loaded. A scroll costs nothing extra: rows live on a ring and only the
//   top pointer and one row's fill count and blank color move.
//   Reset: the screen reads as spaces in color 14 at once, the cursor is at
//   column 0 and the color register is 14; no clearing pass is run.
//   Stall: a result waits in the output register while m_tready is low; the
//   next request is still accepted and completes up to the result step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_top
  import tcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // char_byte[7:0], read_row[12:8], read_col[19:13], zero
  input  logic [1:0]  s_tuser,   // kind[1:0]
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // cell_char[7:0], cell_color[15:8],
                                 // cursor_column[22:16], scrolled[23]
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tcw_cmd_t   cmd;
  logic       cfg_we;
  logic [7:0] text_color;

  // Decode register access
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_TEXT_COLOR);
  assign prdata = (paddr[2] == REG_TEXT_COLOR) ? {24'd0, text_color} : 32'd0;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  tcw_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .in_kind      (s_tuser),
    .in_char_byte (s_tdata[7:0]),
    .in_read_row  (s_tdata[12:8]),
    .in_read_col  (s_tdata[19:13]),
    .cfg_we       (cfg_we),
    .cfg_wdata    (pwdata[7:0]),
    .text_color   (text_color),
    .out_data     (m_tdata)
  );

endmodule

`default_nettype wire

@@ src/tcw_checker.sv @@
// ----------------------------------------------------------------------------
// Text console writer port checker
// Watches the stream ports for request pacing and result consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "text_console_writer_top_assert.svh"

module tcw_checker
  import tcw_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // No result right after reset
  `TCW_ASSERT_ALWAYS(a_reset_clears_valid, rst |=> !m_tvalid, "result valid after reset")

  // A stalled result holds
  `TCW_ASSERT(a_hold_on_stall, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

  // One request at a time
  `TCW_ASSERT(a_one_in_flight, s_tvalid && s_tready |=> !s_tready, "request taken while busy")

  // Cursor never goes beyond the screen width
  `TCW_ASSERT(a_cursor_range, m_tvalid |-> 32'(m_tdata[22:16]) <= SCREEN_COLS, "cursor beyond width")

  // A scroll leaves the cursor at or just after the line start
  `TCW_ASSERT(a_scroll_cursor, m_tvalid && m_tdata[23] |-> m_tdata[22:16] <= 7'd1, "cursor after scroll")

endmodule

bind text_console_writer_top tcw_checker u_tcw_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
